// ===== rtl/tbo_pkg.sv =====
// Shared constants for the triangle/box overlap pipeline.
package tbo_pkg;

  // Default coordinate format: signed Q16.16
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Multiplier slicing and latency
  localparam int CHUNK_W = 32;
  localparam int MUL_LAT = 5;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_X = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MIN_Y = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_MIN_Z = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_MAX_X = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_MAX_Y = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_MAX_Z = REG_IDX_W'(5);

  // Tolerance denominators: 1e-6 on extents, 1e-7 on sign and radius, 1e-5 touch (squared)
  localparam logic [63:0]  EXT_TOL_DEN = 64'd1000000;
  localparam logic [127:0] RAD_TOL_DEN = 128'd10000000;

  // Scale factors applied to plane distances
  localparam int K_W = 35;
  localparam logic signed [K_W-1:0] TOUCH_K = 35'sd10000000000;
  localparam logic signed [K_W-1:0] SIGN_K  = 35'sd10000000;

endpackage

// ===== rtl/triangle_box_overlap_test_top.sv =====
// Streaming triangle versus axis-aligned box overlap test, top level.
//
// Input channel in_*: one triangle per item, nine signed fixed-point coordinates
// (v0 xyz, v1 xyz, v2 xyz) packed in in_tdata. Output channel out_*: one item per
// triangle, out_tdata[0] = 1 when no separating axis exists and the normal is nonzero.
// The box lives in six registers written through cfg_we/cfg_addr/cfg_wdata; write
// them only while no triangle is in flight.
// Throughput: one triangle per clock while in_tready is high. The latency is set by
// the four chained multiplier units (normal, plane distance, distance products,
// tolerance scaling), each five stages deep.
// Reset (rst_n low, synchronous) empties the pipeline and loads the unit box
// [0,1] on each axis.
// When out_tready is low the finished item sits in the output register, one more
// item can land in a skid register, and then in_tready drops and the whole pipeline
// holds until the output drains.
module triangle_box_overlap_test_top #(
  parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tbo_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // overlaps at bit 0, zero fill above
  output logic [7:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_we,
  input  logic [tbo_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [COORD_BITS-1:0] cfg_wdata
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int ML  = tbo_pkg::MUL_LAT;
  localparam int D1  = C + 1;
  localparam int VW  = C + 2;
  localparam int PW  = 2 * C + 8;
  localparam int NW  = 2 * C + 3;
  localparam int NDW = NW + D1;
  localparam int NSW = 2 * NW;
  localparam int TW  = 3 * C + 6;
  localparam int N2W = 4 * C + 8;
  localparam int M3W = 2 * TW;
  localparam int KW  = tbo_pkg::K_W;
  localparam int M4W = M3W + KW;
  localparam int XW  = M4W + 2;

  // pipeline stage numbers
  localparam int S_C = ML + 1;
  localparam int S_D = S_C + 1;
  localparam int S_E = S_D + 1;
  localparam int S_G = S_C + ML;
  localparam int S_H = S_G + 1;
  localparam int S_M = S_H + ML;
  localparam int S_Q = S_M + ML;
  localparam int S_R = S_Q + 1;
  localparam int S_S = S_R + 1;
  localparam int N2_LAST = S_Q - S_H;
  localparam int NZ_LAST = S_R - S_H;
  localparam int F3_LAST = S_R - S_E;

  // tolerances scaled to integer thresholds
  localparam logic signed [D1-1:0] TOL1 =
    D1'((64'd1 << F) / tbo_pkg::EXT_TOL_DEN);
  localparam logic signed [PW-1:0] QK =
    PW'((128'd1 << (2 * F + 2)) / tbo_pkg::RAD_TOL_DEN);

  logic run;
  logic push;

  // box registers
  logic signed [C-1:0] lo_r [3];
  logic signed [C-1:0] hi_r [3];

  // stage 0
  logic signed [C-1:0]  px [3][3];
  logic                 f1_nxt;
  logic signed [D1-1:0] e_nxt [3][3];
  logic signed [D1-1:0] e2_nxt [3];
  logic signed [D1-1:0] dlo_nxt [3];
  logic signed [D1-1:0] dhi_nxt [3];
  logic signed [D1-1:0] hd_nxt [3];
  logic signed [VW-1:0] v_nxt [3][3];
  logic signed [VW-1:0] ae_nxt [3][3];

  logic signed [D1-1:0] e_r [3][3];
  logic signed [D1-1:0] e2_r [3];
  logic signed [D1-1:0] hd_r [3];
  logic signed [VW-1:0] v_r [3][3];
  logic signed [VW-1:0] ae_r [3][3];
  logic signed [D1-1:0] dlo_r [S_C+1][3];
  logic signed [D1-1:0] dhi_r [S_C+1][3];

  logic [S_S:0] vld_r;
  logic         f1_r [S_R+1];
  logic         f3_r [F3_LAST+1];
  logic         nz_r [NZ_LAST+1];
  logic signed [N2W-1:0] n2_r [N2_LAST+1];

  // first multiplier rank outputs
  logic signed [2*D1-1:0]  na_w [3];
  logic signed [2*D1-1:0]  nb_w [3];
  logic signed [D1+VW-1:0] ra_w [3][3];
  logic signed [D1+VW-1:0] rb_w [3][3];
  logic signed [2*VW-1:0]  q1a_w [3][3];
  logic signed [2*VW-1:0]  q1b_w [3][3];
  logic signed [D1+VW-1:0] q2a_w [3][3];
  logic signed [D1+VW-1:0] q2b_w [3][3];

  // cross axis path
  logic signed [NW-1:0] n_c_r [3];
  logic signed [PW-1:0] r_c_r [3][3];
  logic signed [PW-1:0] p1_c_r [3][3];
  logic signed [PW-1:0] p2_c_r [3][3];
  logic signed [PW-1:0] hs_r [3][3];
  logic signed [PW-1:0] ls_r [3][3];
  logic                 f3_nxt;

  // plane path
  logic signed [NDW-1:0] ndlo_w [3];
  logic signed [NDW-1:0] ndhi_w [3];
  logic signed [NSW-1:0] nsq_w [3];
  logic signed [TW-1:0]  t_nxt [8];
  logic signed [TW-1:0]  t_r [8];
  logic signed [M3W-1:0] tt_w [8];
  logic signed [M3W-1:0] tp_w [1:7];
  logic signed [M4W-1:0] ttk_w [8];
  logic signed [M4W-1:0] tpk_w [1:7];
  logic signed [XW-1:0]  s_w;
  logic signed [XW-1:0]  ns_w;
  logic [7:0]            touch_r;
  logic [7:1]            pass_r;
  logic                  res_r;

  // output register and skid
  logic out_v_r;
  logic out_d_r;
  logic skid_v_r;
  logic skid_d_r;

  assign run       = ~skid_v_r;
  assign in_tready = run;
  assign push      = run & vld_r[S_S];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= '0;
        hi_r[k] <= C'(1) << F;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tbo_pkg::REG_MIN_X: lo_r[0] <= cfg_wdata;
        tbo_pkg::REG_MIN_Y: lo_r[1] <= cfg_wdata;
        tbo_pkg::REG_MIN_Z: lo_r[2] <= cfg_wdata;
        tbo_pkg::REG_MAX_X: hi_r[0] <= cfg_wdata;
        tbo_pkg::REG_MAX_Y: hi_r[1] <= cfg_wdata;
        tbo_pkg::REG_MAX_Z: hi_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack vertices
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        px[j][k] = in_tdata[(3*j+k)*C +: C];
      end
    end
  end

  // stage 0: extent test, edges, box-relative terms
  always_comb begin
    logic all_lo;
    logic all_hi;
    int   jn;
    f1_nxt = 1'b1;
    for (int k = 0; k < 3; k++) begin
      all_lo = 1'b1;
      all_hi = 1'b1;
      for (int j = 0; j < 3; j++) begin
        all_lo = all_lo & ((D1'(lo_r[k]) - D1'(px[j][k])) > TOL1);
        all_hi = all_hi & ((D1'(px[j][k]) - D1'(hi_r[k])) > TOL1);
      end
      if (all_lo || all_hi) f1_nxt = 1'b0;
      e2_nxt[k]  = D1'(px[2][k]) - D1'(px[0][k]);
      dlo_nxt[k] = D1'(lo_r[k]) - D1'(px[1][k]);
      dhi_nxt[k] = D1'(hi_r[k]) - D1'(px[1][k]);
      hd_nxt[k]  = D1'(hi_r[k]) - D1'(lo_r[k]);
    end
    for (int j = 0; j < 3; j++) begin
      jn = (j == 2) ? 0 : j + 1;
      for (int k = 0; k < 3; k++) begin
        e_nxt[j][k]  = D1'(px[jn][k]) - D1'(px[j][k]);
        v_nxt[j][k]  = (VW'(px[j][k]) <<< 1) - VW'(hi_r[k]) - VW'(lo_r[k]);
        ae_nxt[j][k] = e_nxt[j][k][D1-1] ? -VW'(e_nxt[j][k]) : VW'(e_nxt[j][k]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (run) begin
      vld_r <= {vld_r[S_S-1:0], in_tvalid};
    end
  end

  // payload stages and delay lines
  always_ff @(posedge clk) begin
    if (run) begin
      e_r  <= e_nxt;
      e2_r <= e2_nxt;
      hd_r <= hd_nxt;
      v_r  <= v_nxt;
      ae_r <= ae_nxt;
      dlo_r[0] <= dlo_nxt;
      dhi_r[0] <= dhi_nxt;
      for (int s = 1; s <= S_C; s++) begin
        dlo_r[s] <= dlo_r[s-1];
        dhi_r[s] <= dhi_r[s-1];
      end
      f1_r[0] <= f1_nxt;
      for (int s = 1; s <= S_R; s++) f1_r[s] <= f1_r[s-1];

      // cross axis: combine products
      for (int k = 0; k < 3; k++) n_c_r[k] <= NW'(na_w[k]) - NW'(nb_w[k]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r_c_r[i][j]  <= (PW'(ra_w[i][j]) + PW'(rb_w[i][j])) <<< 1;
          p1_c_r[i][j] <= PW'(q1a_w[i][j]) - PW'(q1b_w[i][j]);
          p2_c_r[i][j] <= (PW'(q2a_w[i][j]) - PW'(q2b_w[i][j])) <<< 1;
          if (p1_c_r[i][j] > p2_c_r[i][j]) begin
            hs_r[i][j] <= p1_c_r[i][j] + r_c_r[i][j];
            ls_r[i][j] <= p2_c_r[i][j] - r_c_r[i][j];
          end else begin
            hs_r[i][j] <= p2_c_r[i][j] + r_c_r[i][j];
            ls_r[i][j] <= p1_c_r[i][j] - r_c_r[i][j];
          end
        end
      end
      f3_r[0] <= f3_nxt;
      for (int s = 1; s <= F3_LAST; s++) f3_r[s] <= f3_r[s-1];

      // plane: corner distances, normal length
      t_r     <= t_nxt;
      n2_r[0] <= N2W'(nsq_w[0]) + N2W'(nsq_w[1]) + N2W'(nsq_w[2]);
      for (int s = 1; s <= N2_LAST; s++) n2_r[s] <= n2_r[s-1];
      nz_r[0] <= (nsq_w[0] != '0) | (nsq_w[1] != '0) | (nsq_w[2] != '0);
      for (int s = 1; s <= NZ_LAST; s++) nz_r[s] <= nz_r[s-1];

      // corner classification
      for (int i = 0; i < 8; i++) touch_r[i] <= XW'(ttk_w[i]) <= s_w;
      for (int i = 1; i < 8; i++) pass_r[i] <= XW'(tpk_w[i]) < ns_w;

      res_r <= f1_r[S_R] & f3_r[F3_LAST] & nz_r[NZ_LAST] &
               ((|pass_r) | ($countones(touch_r) > 2));
    end
  end

  // cross axis interval test against the scaled radius tolerance
  always_comb begin
    f3_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((hs_r[i][j] < -QK) || (ls_r[i][j] > QK)) f3_nxt = 1'b0;
      end
    end
  end

  // corner distances: pick low or high box face per axis
  always_comb begin
    logic [2:0] sel;
    for (int i = 0; i < 8; i++) begin
      sel[0] = ((i ^ (i >> 1)) & 1) == 1;
      sel[1] = ((i >> 1) & 1) == 1;
      sel[2] = ((i >> 2) & 1) == 1;
      t_nxt[i] = '0;
      for (int k = 0; k < 3; k++) begin
        t_nxt[i] = t_nxt[i] + (sel[k] ? TW'(ndhi_w[k]) : TW'(ndlo_w[k]));
      end
    end
  end

  assign s_w  = XW'(n2_r[N2_LAST]) <<< (2 * F);
  assign ns_w = -s_w;

  // normal components, their distance products with both box faces, and their squares
  for (genvar gk = 0; gk < 3; gk++) begin : g_nrm
    localparam int K1 = (gk + 1) % 3;
    localparam int K2 = (gk + 2) % 3;
    tbo_mul #(.WA(D1), .WB(D1)) u_na (
      .clk(clk), .en(run), .a(e_r[0][K1]), .b(e2_r[K2]), .p(na_w[gk]));
    tbo_mul #(.WA(D1), .WB(D1)) u_nb (
      .clk(clk), .en(run), .a(e_r[0][K2]), .b(e2_r[K1]), .p(nb_w[gk]));
    tbo_mul #(.WA(NW), .WB(D1)) u_ndlo (
      .clk(clk), .en(run), .a(n_c_r[gk]), .b(dlo_r[S_C][gk]), .p(ndlo_w[gk]));
    tbo_mul #(.WA(NW), .WB(D1)) u_ndhi (
      .clk(clk), .en(run), .a(n_c_r[gk]), .b(dhi_r[S_C][gk]), .p(ndhi_w[gk]));
    tbo_mul #(.WA(NW), .WB(NW)) u_nsq (
      .clk(clk), .en(run), .a(n_c_r[gk]), .b(n_c_r[gk]), .p(nsq_w[gk]));
  end

  // edge-cross-axis projections and radii, one per box axis and triangle edge
  for (genvar gi = 0; gi < 3; gi++) begin : g_ax
    for (genvar gj = 0; gj < 3; gj++) begin : g_ed
      localparam int A1 = (gi + 1) % 3;
      localparam int A2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      tbo_mul #(.WA(D1), .WB(VW)) u_ra (
        .clk(clk), .en(run), .a(hd_r[A1]), .b(ae_r[gj][A2]), .p(ra_w[gi][gj]));
      tbo_mul #(.WA(D1), .WB(VW)) u_rb (
        .clk(clk), .en(run), .a(hd_r[A2]), .b(ae_r[gj][A1]), .p(rb_w[gi][gj]));
      tbo_mul #(.WA(VW), .WB(VW)) u_q1a (
        .clk(clk), .en(run), .a(v_r[gj][A2]), .b(v_r[J1][A1]), .p(q1a_w[gi][gj]));
      tbo_mul #(.WA(VW), .WB(VW)) u_q1b (
        .clk(clk), .en(run), .a(v_r[gj][A1]), .b(v_r[J1][A2]), .p(q1b_w[gi][gj]));
      tbo_mul #(.WA(D1), .WB(VW)) u_q2a (
        .clk(clk), .en(run), .a(e_r[gj][A1]), .b(v_r[J2][A2]), .p(q2a_w[gi][gj]));
      tbo_mul #(.WA(D1), .WB(VW)) u_q2b (
        .clk(clk), .en(run), .a(e_r[gj][A2]), .b(v_r[J2][A1]), .p(q2b_w[gi][gj]));
    end
  end

  // corner distance squares and products with corner zero, then scaling
  for (genvar gc = 0; gc < 8; gc++) begin : g_cor
    tbo_mul #(.WA(TW), .WB(TW)) u_tt (
      .clk(clk), .en(run), .a(t_r[gc]), .b(t_r[gc]), .p(tt_w[gc]));
    tbo_mul #(.WA(M3W), .WB(KW)) u_ttk (
      .clk(clk), .en(run), .a(tt_w[gc]), .b(tbo_pkg::TOUCH_K), .p(ttk_w[gc]));
    if (gc > 0) begin : g_sgn
      tbo_mul #(.WA(TW), .WB(TW)) u_tp (
        .clk(clk), .en(run), .a(t_r[0]), .b(t_r[gc]), .p(tp_w[gc]));
      tbo_mul #(.WA(M3W), .WB(KW)) u_tpk (
        .clk(clk), .en(run), .a(tp_w[gc]), .b(tbo_pkg::SIGN_K), .p(tpk_w[gc]));
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
        out_d_r <= res_r;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
      skid_d_r <= res_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_d_r};

`ifndef NO_ASSERTIONS
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled while output was free");
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item ahead of an empty output");
  a_extent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    run && vld_r[S_R] && !f1_r[S_R] |=> !res_r)
    else $error("extent separation did not clear the result");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    run && vld_r[S_R] && !nz_r[NZ_LAST] |=> !res_r)
    else $error("degenerate triangle reported as overlapping");
`endif

endmodule

// ===== rtl/tbo_mul.sv =====
// Pipelined exact signed multiplier built from 32x32 partial products.
module tbo_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int CW  = tbo_pkg::CHUNK_W;
  localparam int NA  = (WA + CW - 1) / CW;
  localparam int NB  = (WB + CW - 1) / CW;
  localparam int PWD = CW * (NA + NB);
  localparam int SGN = tbo_pkg::MUL_LAT - 1;

  logic [WA-1:0]        ua;
  logic [WB-1:0]        ub;
  logic [CW*NA-1:0]     ma_r;
  logic [CW*NB-1:0]     mb_r;
  logic [SGN-1:0]       sg_r;
  logic [2*CW-1:0]      pp_r [NA][NB];
  logic [PWD-1:0]       row_nxt [NA];
  logic [PWD-1:0]       row_r [NA];
  logic [PWD-1:0]       tot_nxt;
  logic [PWD-1:0]       tot_r;
  logic signed [WA+WB-1:0] prod_r;

  // magnitudes of the operands
  always_comb begin
    ua = a[WA-1] ? (~a + 1'b1) : a;
    ub = b[WB-1] ? (~b + 1'b1) : b;
  end

  // row sums of partial products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (PWD'(pp_r[i][j]) << (CW * j));
      end
    end
  end

  // final sum over rows
  always_comb begin
    tot_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      tot_nxt = tot_nxt + (row_r[i] << (CW * i));
    end
  end

  // five register stages: magnitude, partials, rows, total, sign
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= (CW*NA)'(ua);
      mb_r <= (CW*NB)'(ub);
      sg_r <= {sg_r[SGN-2:0], a[WA-1] ^ b[WB-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ma_r[CW*i +: CW] * mb_r[CW*j +: CW];
        end
      end
      row_r  <= row_nxt;
      tot_r  <= tot_nxt;
      prod_r <= (WA+WB)'(sg_r[SGN-1] ? (~tot_r + 1'b1) : tot_r);
    end
  end

  assign p = prod_r;

endmodule
